// ===== src/csvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvrt_pkg
// types and constants shared by the csv record tokenizer and its checker
// ----------------------------------------------------------------------------
package csvrt_pkg;

    localparam logic [7:0] CR_BYTE     = 8'd13;
    localparam logic [7:0] LF_BYTE     = 8'd10;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // configuration register indexes
    localparam logic CFG_DELIMITER  = 1'b0;
    localparam logic CFG_QUOTE_CHAR = 1'b1;

    localparam int unsigned FIELD_W = 8;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } t_kind;

    // per-line parser state
    typedef struct packed {
        logic               quoted;     // inside quoted text
        logic               qpend;      // quote seen inside quotes, meaning pending
        logic               cr_seen;    // last byte was cr, swallow a following lf
        logic               has_bytes;  // current line holds at least one byte
        logic [FIELD_W-1:0] field;      // field index within the record
        logic               hdr_done;   // first record has ended
    } t_state;

    // token produced by one byte
    typedef struct packed {
        logic               emit;
        t_kind              kind;
        logic [7:0]         tbyte;
    } t_token;

endpackage

// ===== src/csvrt_step.sv =====
// ----------------------------------------------------------------------------
// csvrt_step
// next-state and token logic for one byte of csv text
// ----------------------------------------------------------------------------
module csvrt_step
    import csvrt_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    input  logic [7:0] i_delim,
    input  logic [7:0] i_quote,
    output t_state     o_state,
    output t_token     o_token
);

    always_comb begin
        t_state n;
        t_token t;
        logic   skip;
        logic   lit;
        logic   quoted;

        n      = i_state;
        t.emit = 1'b0;
        t.kind = KIND_DATA;
        t.tbyte = '0;
        skip   = 1'b0;
        lit    = 1'b0;
        quoted = i_state.quoted;

        if (i_eot) begin
            // flush an unterminated line, then start a fresh text
            if (i_state.has_bytes) begin
                t.emit = 1'b1;
                t.kind = KIND_RECORD_END;
            end
            n = '0;
        end else begin
            if (i_state.cr_seen) begin
                n.cr_seen = 1'b0;
                if (i_byte == LF_BYTE) begin
                    skip = 1'b1;
                end
            end
            if (!skip) begin
                if (i_byte == CR_BYTE || i_byte == LF_BYTE) begin
                    n.cr_seen = (i_byte == CR_BYTE);
                    n.quoted  = 1'b0;
                    n.qpend   = 1'b0;
                    if (i_state.has_bytes) begin
                        t.emit      = 1'b1;
                        t.kind      = KIND_RECORD_END;
                        n.hdr_done  = 1'b1;
                        n.field     = '0;
                        n.has_bytes = 1'b0;
                    end
                end else begin
                    n.has_bytes = 1'b1;
                    if (i_state.qpend) begin
                        n.qpend = 1'b0;
                        if (i_byte == i_quote) begin
                            lit = 1'b1;
                        end else begin
                            quoted   = 1'b0;
                            n.quoted = 1'b0;
                        end
                    end
                    if (lit) begin
                        // doubled quote gives one literal quote
                        t.emit  = 1'b1;
                        t.tbyte = i_byte;
                    end else if (quoted) begin
                        if (i_byte == i_quote) begin
                            n.qpend = 1'b1;
                        end else begin
                            t.emit  = 1'b1;
                            t.tbyte = i_byte;
                        end
                    end else if (i_byte == i_quote) begin
                        n.quoted = 1'b1;
                    end else if (i_byte == i_delim) begin
                        t.emit = 1'b1;
                        t.kind = KIND_FIELD_END;
                        if (i_state.field != FIELD_MAX) begin
                            n.field = i_state.field + 1'b1;
                        end
                    end else begin
                        t.emit  = 1'b1;
                        t.tbyte = i_byte;
                    end
                end
            end
        end

        o_state = n;
        o_token = t;
    end

endmodule

// ===== src/csv_record_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// csv_record_tokenizer_unit
// streaming csv tokenizer: one text byte in, at most one token out
// ----------------------------------------------------------------------------
// Takes one byte of csv text per transaction on the slave side (tlast marks
// the end of the text and flushes an unterminated line) and returns field data
// bytes, field ends and record ends on the master side, tagged with the field
// index and a header flag. The unit sustains one byte per clock cycle while
// the master side does not stall: each byte passes an input register and then
// a result register before its token is presented, and bytes that yield no
// token (opening quotes, line ends on empty lines, the lf of a cr lf pair)
// simply vanish. The user must write delimiter and quote byte through the
// configuration port only while the unit is idle; the unit itself does not
// enforce it. They reset to comma and double quote.
// ----------------------------------------------------------------------------
module csv_record_tokenizer_unit
    import csvrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration writes: index 0 delimiter, index 1 quote byte
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,

    // text bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_text

    // tokens
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] token_byte, [15:8] field_index
    output logic [2:0]  m_axis_tuser    // [1:0] token_kind, [2] in_header
);

    // configuration registers
    logic [7:0] r_delim;
    logic [7:0] r_quote;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_quote <= QUOTE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELIMITER:  r_delim <= i_cfg_data;
                CFG_QUOTE_CHAR: r_quote <= i_cfg_data;
                default:        r_delim <= r_delim;
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;

    // result register
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [7:0]         r_out_byte;
    logic [FIELD_W-1:0] r_out_field;
    logic               r_out_hdr;

    // parser state
    t_state r_state;
    t_state n_state;
    t_token w_token;

    logic w_out_free;
    logic w_fire;

    // result slot is free when empty or being drained this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;
    // byte in the input register is parsed once its token has a place to go
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    csvrt_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .i_delim (r_delim),
        .i_quote (r_quote),
        .o_state (n_state),
        .o_token (w_token)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && w_token.emit;
        end
    end

    // field index and header flag belong to the state before this byte
    always_ff @(posedge i_clk) begin
        if (w_fire && w_token.emit) begin
            r_out_kind  <= w_token.kind;
            r_out_byte  <= w_token.tbyte;
            r_out_field <= r_state.field;
            r_out_hdr   <= !r_state.hdr_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_field, r_out_byte};
    assign m_axis_tuser  = {r_out_hdr, r_out_kind};

endmodule

// ===== src/csvrt_checker.sv =====
// ----------------------------------------------------------------------------
// csvrt_checker
// port-level checks for the csv record tokenizer, bound to the top level
// ----------------------------------------------------------------------------
module csvrt_checker
    import csvrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser
);

    // a stalled token holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("token changed while stalled");

    // only the three token kinds ever leave the unit
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] == KIND_DATA ||
                           m_axis_tuser[1:0] == KIND_FIELD_END ||
                           m_axis_tuser[1:0] == KIND_RECORD_END))
        else $error("illegal token kind");

    // field and record ends carry a zero byte
    a_end_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] != KIND_DATA) |->
            (m_axis_tdata[7:0] == 8'd0))
        else $error("end token with non-zero byte");

    // nothing is presented straight after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("token presented right after reset");

endmodule

bind csv_record_tokenizer_unit csvrt_checker u_csvrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/csv_record_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_tokenizer_unit_tb
// self-checking bench for the streaming csv tokenizer
// ----------------------------------------------------------------------------
// Text bytes are pushed through the slave stream while a local model of the
// tokenizer state predicts every token. The master stream is drained with
// random back-pressure, and each token transaction is compared field by field
// against the oldest prediction. Directed tests cover quoting, line ends,
// end-of-text flushing, register overlap and field index saturation. Random
// tests then send mostly well-formed records under several separator
// settings and idle patterns.
// ----------------------------------------------------------------------------
module csv_record_tokenizer_unit_tb;
    import csvrt_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    // input register plus result register, with some margin
    localparam int unsigned SETTLE_LIMIT = 8;

    // one predicted token as it should appear on the master side
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tbyte;
        logic [7:0] field;
        logic       in_hdr;
    } t_token_exp;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_idx     = CFG_DELIMITER;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // model of the parser state and the separator registers
    t_state      tok_state  = '0;
    logic [7:0]  cfg_delim  = DELIM_RESET;
    logic [7:0]  cfg_quote  = QUOTE_RESET;

    t_token_exp  expected_tokens[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned bytes_sent    = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;

    csv_record_tokenizer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------------

    task automatic push_token(input t_kind kind, input logic [7:0] tbyte);
        t_token_exp tok;
        tok.kind   = kind;
        tok.tbyte  = tbyte;
        tok.field  = tok_state.field;
        tok.in_hdr = !tok_state.hdr_done;
        expected_tokens.insert(expected_tokens.size(), tok);
    endtask

    // closing a record also leaves the header behind and restarts the line
    task automatic push_record_end();
        push_token(KIND_RECORD_END, 8'd0);
        tok_state.hdr_done  = 1'b1;
        tok_state.field     = '0;
        tok_state.quoted    = 1'b0;
        tok_state.qpend     = 1'b0;
        tok_state.has_bytes = 1'b0;
    endtask

    task automatic predict_tokens(input logic [7:0] b, input logic eot);
        // end of text: flush a line with bytes, then back to a fresh text
        if (eot) begin
            if (tok_state.has_bytes)
                push_record_end();
            tok_state = '0;
            return;
        end
        // lf straight after a cr belongs to the same line end
        if (tok_state.cr_seen) begin
            tok_state.cr_seen = 1'b0;
            if (b == LF_BYTE)
                return;
        end
        // line ends win over delimiter and quote, even inside quotes
        if (b == CR_BYTE || b == LF_BYTE) begin
            if (b == CR_BYTE)
                tok_state.cr_seen = 1'b1;
            tok_state.quoted = 1'b0;
            tok_state.qpend  = 1'b0;
            if (tok_state.has_bytes)
                push_record_end();
            return;
        end
        tok_state.has_bytes = 1'b1;
        // a quote inside quotes: doubled gives a literal, lone closes quoting
        if (tok_state.qpend) begin
            tok_state.qpend = 1'b0;
            if (b == cfg_quote) begin
                push_token(KIND_DATA, b);
                return;
            end
            tok_state.quoted = 1'b0;
        end
        if (tok_state.quoted) begin
            if (b == cfg_quote)
                tok_state.qpend = 1'b1;
            else
                push_token(KIND_DATA, b);
            return;
        end
        // unquoted: quote test ahead of delimiter test
        if (b == cfg_quote) begin
            tok_state.quoted = 1'b1;
            return;
        end
        if (b == cfg_delim) begin
            push_token(KIND_FIELD_END, 8'd0);
            if (tok_state.field != FIELD_MAX)
                tok_state.field = tok_state.field + 1'b1;
            return;
        end
        push_token(KIND_DATA, b);
    endtask

    // ------------------------------------------------------------------------
    // master side: random back-pressure and token checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // values read here are the ones that stood before this edge
    always @(posedge i_clk) begin : token_checker
        t_token_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: kind %0d, byte %0d, field %0d",
                       m_axis_tuser[1:0], m_axis_tdata[7:0], m_axis_tdata[15:8]);
                fail_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.kind, m_axis_tuser[1:0]);
                check_field("token_byte", want.tbyte, m_axis_tdata[7:0]);
                check_field("field_index", want.field, m_axis_tdata[15:8]);
                check_field("in_header", want.in_hdr, m_axis_tuser[2]);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // slave side
    // ------------------------------------------------------------------------

    // one byte transaction; valid stays high across back-to-back bytes
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predict_tokens(b, eot);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_text_byte(s[i], 1'b0);
    endtask

    // the data byte rides along with the end marker but must be ignored
    task automatic send_end_marker();
        send_text_byte(8'($urandom_range(255)), 1'b1);
    endtask

    // hold the sender until every predicted token has come back
    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_LIMIT) @(posedge i_clk);
    endtask

    task automatic configure_separators(input logic [7:0] delim, input logic [7:0] quote);
        drain_tokens();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DELIMITER;
        i_cfg_data <= delim;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_QUOTE_CHAR;
        i_cfg_data <= quote;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_delim = delim;
        cfg_quote = quote;
    endtask

    // ------------------------------------------------------------------------
    // random text generation
    // ------------------------------------------------------------------------

    // a byte that is plain field content under the current separators
    function automatic logic [7:0] pick_field_byte(input bit in_quotes);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CR_BYTE || b == LF_BYTE || b == cfg_quote ||
               (!in_quotes && b == cfg_delim));
        return b;
    endfunction

    // a well-formed record: quoted and plain fields, then a line end or an end marker
    task automatic send_random_record();
        int unsigned n_fields;
        int unsigned len;
        n_fields = $urandom_range(1, 6);
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0)
                send_text_byte(cfg_delim, 1'b0);
            len = $urandom_range(0, 5);
            if ($urandom_range(2) == 0) begin
                send_text_byte(cfg_quote, 1'b0);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(5) == 0) begin
                        send_text_byte(cfg_quote, 1'b0);
                        send_text_byte(cfg_quote, 1'b0);
                    end else begin
                        send_text_byte(pick_field_byte(1'b1), 1'b0);
                    end
                end
                send_text_byte(cfg_quote, 1'b0);
            end else begin
                for (int i = 0; i < len; i++)
                    send_text_byte(pick_field_byte(1'b0), 1'b0);
            end
        end
        case ($urandom_range(3))
            0: send_text_byte(LF_BYTE, 1'b0);
            1: send_text_byte(CR_BYTE, 1'b0);
            2: begin
                send_text_byte(CR_BYTE, 1'b0);
                send_text_byte(LF_BYTE, 1'b0);
            end
            default: send_end_marker();
        endcase
    endtask

    // noise leans on the bytes that matter to the parser
    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(4))
            0: return cfg_delim;
            1: return cfg_quote;
            2: return CR_BYTE;
            3: return LF_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // quoting, line ends and end-of-text handling with default separators
    task automatic test_directed_text();
        // empty first line, then a header with a doubled quote,
        // a trailing empty field and a cr lf line end
        send_text("\na,\"b\"\"c\",\015\n");
        // lone quote closes quoting, cr cr leaves an empty line
        send_text("\"x\"y\015\015z\n");
        // unterminated line with a pending quote at the end marker
        send_text("\"q\"");
        send_end_marker();
        // end marker on an empty line emits nothing
        send_end_marker();
        // extreme data bytes start a new text, hence a new header
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_end_marker();
    endtask

    // separators that collide with each other or with line ends
    task automatic test_register_overlap();
        // delimiter equal to quote: the quote meaning wins
        configure_separators(8'h7C, 8'h7C);
        send_text("a|b|c\n");
        // cr as delimiter and lf as quote still end the line
        configure_separators(CR_BYTE, LF_BYTE);
        send_text("x\015y\n\"");
        send_end_marker();
        configure_separators(DELIM_RESET, QUOTE_RESET);
    endtask

    // field index stops at its maximum on a very wide record
    task automatic test_field_saturation();
        repeat (260) send_text_byte(cfg_delim, 1'b0);
        send_text_byte(LF_BYTE, 1'b0);
    endtask

    task automatic test_random_text(input int unsigned send_pct, input int unsigned recv_pct,
                                    input logic [7:0] delim, input logic [7:0] quote,
                                    input int unsigned n_bytes);
        int unsigned sel;
        configure_separators(delim, quote);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        bytes_sent = 0;
        while (bytes_sent < n_bytes) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                send_random_record();
            end else if (sel < 82) begin
                send_text_byte($urandom_range(1) ? CR_BYTE : LF_BYTE, 1'b0);
            end else if (sel < 98) begin
                repeat ($urandom_range(1, 4))
                    send_text_byte(pick_noise_byte(), $urandom_range(15) == 0);
            end else begin
                drain_tokens();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 7;
        recv_idle_pct = 45;
        test_directed_text();
        test_register_overlap();
        test_field_saturation();

        test_random_text(7, 45, DELIM_RESET, QUOTE_RESET, 40);
        test_random_text(45, 7, 8'h00, 8'hFF, 40);
        test_random_text(0, 0, 8'hFF, 8'h00, 40);

        drain_tokens();
        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
